[rtl/core/ray_box_slab_test_unit_macros.svh]
// Assertion macros used by the checker of the ray box unit.
`ifndef RAY_BOX_SLAB_TEST_UNIT_MACROS_SVH
`define RAY_BOX_SLAB_TEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RBST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbst assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbst assertion failed");

`endif

[rtl/core/rbst_pkg.sv]
`default_nettype none
package rbst_pkg;

    localparam int AXES       = 3;
    localparam int LANES      = 2 * AXES;
    localparam int DIV_STAGES = 32;
    localparam int IN_BITS    = 12 * 32;

    localparam logic [31:0] T_LO = 32'h8000_0000;
    localparam logic [31:0] T_HI = 32'h7fff_ffff;

    // One plane distance under division: magnitude remainder, divisor, quotient.
    typedef struct packed {
        logic [48:0] rem;
        logic [31:0] den;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic  [AXES-1:0]  dz;
        logic              miss;
    } div_item_t;

    typedef struct packed {
        logic [AXES-1:0][31:0] lo;
        logic [AXES-1:0][31:0] hi;
        logic                  miss;
    } slab_t;

    typedef struct packed {
        logic [31:0] entry;
        logic [31:0] exit_v;
        logic        miss;
    } span_t;

    function automatic lane_t make_lane(input logic [31:0] p, input logic [31:0] o,
                                        input logic [31:0] d);
        logic [32:0] diff;
        logic [32:0] mag;
        logic [31:0] den;
        lane_t       l;
        diff = {p[31], p} - {o[31], o};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
        if (d == 32'd0)
        begin
            den = 32'd1;
        end
        else
        begin
            den = d[31] ? (~d + 32'd1) : d;
        end
        l.rem = {mag, 16'b0};
        l.den = den;
        l.quo = '0;
        l.neg = diff[32] ^ d[31];
        l.ovf = ({15'b0, mag[32:16]} >= den);
        return l;
    endfunction

    // Restoring division, one quotient bit.
    function automatic lane_t div_step(input lane_t l, input logic [4:0] sh);
        logic [63:0] part;
        logic [63:0] sub;
        lane_t       r;
        r    = l;
        part = {15'b0, l.rem} >> sh;
        sub  = {32'b0, l.den} << sh;
        if (part >= {32'b0, l.den})
        begin
            r.rem     = l.rem - sub[48:0];
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

    // Apply sign and saturate to the signed 32-bit range.
    function automatic logic [31:0] finish_lane(input lane_t l);
        logic [31:0] t;
        if (l.ovf)
        begin
            t = l.neg ? T_LO : T_HI;
        end
        else if (l.neg)
        begin
            t = (l.quo > T_LO) ? T_LO : (~l.quo + 32'd1);
        end
        else
        begin
            t = l.quo[31] ? T_HI : l.quo;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

[rtl/core/rbst_prep.sv]
`default_nettype none
module rbst_prep (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rbst_pkg::IN_BITS-1:0] in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output rbst_pkg::div_item_t               out_data
);

    logic                valid_reg;
    rbst_pkg::div_item_t item_reg;
    rbst_pkg::div_item_t item_next;

    always_comb
    begin
        item_next      = '0;
        item_next.miss = 1'b0;
        for (int a = 0; a < rbst_pkg::AXES; a++)
        begin
            item_next.lane[2*a]   = rbst_pkg::make_lane(in_data[(6+a)*32 +: 32],
                                                        in_data[a*32 +: 32],
                                                        in_data[(3+a)*32 +: 32]);
            item_next.lane[2*a+1] = rbst_pkg::make_lane(in_data[(9+a)*32 +: 32],
                                                        in_data[a*32 +: 32],
                                                        in_data[(3+a)*32 +: 32]);
            item_next.dz[a] = (in_data[(3+a)*32 +: 32] == 32'd0);
            // zero direction: origin must lie between the planes, either order
            if (item_next.dz[a] &&
                !((($signed(in_data[a*32 +: 32]) >= $signed(in_data[(6+a)*32 +: 32])) &&
                   ($signed(in_data[a*32 +: 32]) <= $signed(in_data[(9+a)*32 +: 32]))) ||
                  (($signed(in_data[a*32 +: 32]) >= $signed(in_data[(9+a)*32 +: 32])) &&
                   ($signed(in_data[a*32 +: 32]) <= $signed(in_data[(6+a)*32 +: 32])))))
            begin
                item_next.miss = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/rbst_div_pipe.sv]
`default_nettype none
module rbst_div_pipe (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rbst_pkg::div_item_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rbst_pkg::div_item_t      out_data
);

    logic                stage_v [rbst_pkg::DIV_STAGES];
    rbst_pkg::div_item_t stage_d [rbst_pkg::DIV_STAGES];
    logic [rbst_pkg::DIV_STAGES:0] rdy;

    assign rdy[rbst_pkg::DIV_STAGES] = out_ready;

    for (genvar k = 0; k < rbst_pkg::DIV_STAGES; k++)
    begin : g_stage
        logic                valid_reg;
        rbst_pkg::div_item_t item_reg;
        rbst_pkg::div_item_t item_next;
        logic                src_v;
        rbst_pkg::div_item_t src_d;

        if (k == 0)
        begin : g_first
            assign src_v = in_valid;
            assign src_d = in_data;
        end
        else
        begin : g_rest
            assign src_v = stage_v[k-1];
            assign src_d = stage_d[k-1];
        end

        // Stage k resolves quotient bit 31-k of every lane.
        always_comb
        begin
            item_next = src_d;
            for (int j = 0; j < rbst_pkg::LANES; j++)
            begin
                item_next.lane[j] = rbst_pkg::div_step(src_d.lane[j],
                                                       5'(rbst_pkg::DIV_STAGES - 1 - k));
            end
        end

        assign rdy[k]     = !valid_reg || rdy[k+1];
        assign stage_v[k] = valid_reg;
        assign stage_d[k] = item_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v)
            begin
                item_reg <= item_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = stage_v[rbst_pkg::DIV_STAGES-1];
    assign out_data  = stage_d[rbst_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/core/rbst_slab.sv]
`default_nettype none
module rbst_slab (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rbst_pkg::div_item_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rbst_pkg::span_t          out_data
);

    logic            slab_valid_reg;
    rbst_pkg::slab_t slab_reg;
    rbst_pkg::slab_t slab_next;
    logic            span_valid_reg;
    rbst_pkg::span_t span_reg;
    rbst_pkg::span_t span_next;
    logic            slab_rdy;
    logic            span_rdy;

    // Sign, saturate, order the two planes of each axis; a zero-direction axis spans the full range.
    always_comb
    begin
        slab_next      = '0;
        slab_next.miss = in_data.miss;
        for (int a = 0; a < rbst_pkg::AXES; a++)
        begin
            if (in_data.dz[a])
            begin
                slab_next.lo[a] = rbst_pkg::T_LO;
                slab_next.hi[a] = rbst_pkg::T_HI;
            end
            else if ($signed(rbst_pkg::finish_lane(in_data.lane[2*a])) <
                     $signed(rbst_pkg::finish_lane(in_data.lane[2*a+1])))
            begin
                slab_next.lo[a] = rbst_pkg::finish_lane(in_data.lane[2*a]);
                slab_next.hi[a] = rbst_pkg::finish_lane(in_data.lane[2*a+1]);
            end
            else
            begin
                slab_next.lo[a] = rbst_pkg::finish_lane(in_data.lane[2*a+1]);
                slab_next.hi[a] = rbst_pkg::finish_lane(in_data.lane[2*a]);
            end
        end
    end

    // Keep the largest entry and the smallest exit.
    always_comb
    begin
        span_next.entry  = rbst_pkg::T_LO;
        span_next.exit_v = rbst_pkg::T_HI;
        span_next.miss   = slab_reg.miss;
        for (int a = 0; a < rbst_pkg::AXES; a++)
        begin
            if ($signed(slab_reg.lo[a]) > $signed(span_next.entry))
            begin
                span_next.entry = slab_reg.lo[a];
            end
            if ($signed(slab_reg.hi[a]) < $signed(span_next.exit_v))
            begin
                span_next.exit_v = slab_reg.hi[a];
            end
        end
    end

    assign span_rdy  = !span_valid_reg || out_ready;
    assign slab_rdy  = !slab_valid_reg || span_rdy;
    assign in_ready  = slab_rdy;
    assign out_valid = span_valid_reg;
    assign out_data  = span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slab_valid_reg <= 1'b0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            if (slab_rdy)
            begin
                slab_valid_reg <= in_valid;
            end
            if (span_rdy)
            begin
                span_valid_reg <= slab_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slab_rdy && in_valid)
        begin
            slab_reg <= slab_next;
        end
        if (span_rdy && slab_valid_reg)
        begin
            span_reg <= span_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ray_box_slab_test_unit.sv]
// Ray versus axis-aligned box slab test, signed Q16.16.
// An accepted input passes the prep register, the 32 divider stages, the slab and span registers and the
// output register before its result shows on m_tvalid; one transaction per cycle unless m_tready stalls it.
// Reset (rst_n low, asynchronous): all pipeline valid bits clear, max_distance
// returns to 0x7FFFFFFF.
`default_nettype none
module ray_box_slab_test_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // s_tdata from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rbst_pkg::IN_BITS-1:0] s_tdata,
    // m_tdata: distance (signed Q16.16)
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [31:0]                       m_tdata,
    // m_tuser: hit
    output logic                              m_tuser,
    // max_distance register write channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [30:0]                  cfg_data
);

    logic                prep_valid;
    logic                prep_ready;
    rbst_pkg::div_item_t prep_data;
    logic                div_valid;
    logic                div_ready;
    rbst_pkg::div_item_t div_data;
    logic                span_valid;
    logic                span_ready;
    rbst_pkg::span_t     span_data;

    logic [30:0] max_dist_reg;
    logic        out_valid_reg;
    logic [31:0] out_dist_reg;
    logic        out_hit_reg;
    logic        hit_next;
    logic [31:0] floor0;

    // Stage 0: plane offsets, magnitudes, overflow check, zero-direction test.
    rbst_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // Stages 1..32: six restoring dividers, one quotient bit per stage.
    rbst_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // Stages 33..34: saturate, order planes, reduce to entry and exit.
    rbst_slab u_slab (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (span_valid),
        .out_ready (span_ready),
        .out_data  (span_data)
    );

    // Final decision: miss if the zero-direction test failed, exit is behind max(0, entry) or entry is out of range.
    always_comb
    begin
        floor0   = span_data.entry[31] ? 32'd0 : span_data.entry;
        hit_next = !span_data.miss;
        if ($signed(span_data.exit_v) < $signed(floor0))
        begin
            hit_next = 1'b0;
        end
        if (!span_data.entry[31] && (span_data.entry[30:0] >= max_dist_reg))
        begin
            hit_next = 1'b0;
        end
    end

    // Output register: hold the result until the receiver takes it.
    assign span_ready = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_dist_reg;
    assign m_tuser    = out_hit_reg;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_dist_reg  <= 31'h7fff_ffff;
        end
        else
        begin
            if (span_ready)
            begin
                out_valid_reg <= span_valid;
            end
            if (cfg_valid)
            begin
                max_dist_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_ready && span_valid)
        begin
            out_hit_reg  <= hit_next;
            out_dist_reg <= hit_next ? span_data.entry : 32'd0;
        end
    end

endmodule
`default_nettype wire

[rtl/core/rbst_checker.sv]
`default_nettype none
`include "ray_box_slab_test_unit_macros.svh"
module rbst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result holds.
    `RBST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // A miss carries zero distance.
    `RBST_ASSERT_IMPL(a_miss_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == 32'd0)
    // No hit can sit at the largest positive distance: the range limit excludes it.
    `RBST_ASSERT_IMPL(a_hit_range, clk, rst_n, m_tvalid && m_tuser, m_tdata != 32'h7fff_ffff)

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
